### src/t4p2rgb_pkg.sv
// shared types and constants for the tiled 4bpp palette to rgb888 converter
// no dependencies
`default_nettype none

package t4p2rgb_pkg;

  localparam int unsigned IconDimDef  = 32;
  localparam int unsigned PalDepth    = 16;
  localparam int unsigned PalIdxW     = 4;
  localparam int unsigned ColourW     = 15;
  localparam int unsigned ChanW       = 5;
  localparam int unsigned CoordW      = 5;
  localparam int unsigned TileSubW    = 5;
  localparam int unsigned QueueDepth  = 2;

  localparam logic FuncPalette = 1'b0;
  localparam logic FuncPixels  = 1'b1;

  typedef struct packed {
    logic                 func;
    logic [PalIdxW-1:0]   palette_index;
    logic [ColourW-1:0]   palette_color;
    logic [7:0]           pixel_byte;
  } pixel_in_t;

  typedef struct packed {
    logic [CoordW-1:0]    pixel_x;
    logic [CoordW-1:0]    pixel_y;
    logic [7:0]           red;
    logic [7:0]           green;
    logic [7:0]           blue;
    logic                 last;
    logic                 icon_done;
  } pixel_out_t;

  // placement of one byte within the icon
  typedef struct packed {
    logic [1:0]           x_hi;
    logic [1:0]           y_hi;
    logic [TileSubW-1:0]  sub;
    logic                 done;
  } tile_pos_t;

  typedef struct packed {
    pixel_in_t            req;
    tile_pos_t            pos;
  } queue_entry_t;

  typedef struct packed {
    logic [CoordW-1:0]    pixel_x;
    logic [CoordW-1:0]    pixel_y;
    logic                 last;
    logic                 icon_done;
  } pixel_meta_t;

  function automatic logic [7:0] expand_chan(logic [ChanW-1:0] c);
    return {c, 3'b000};
  endfunction

endpackage

`default_nettype wire

### src/t4p2rgb_ram.sv
// generic single write port ram with registered read
// no dependencies
`default_nettype none

module t4p2rgb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output      logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### src/t4p2rgb_front.sv
// front end: takes requests, tracks the byte position in the tiled icon
// depends on t4p2rgb_pkg
`default_nettype none

module t4p2rgb_front
  import t4p2rgb_pkg::*;
#(
  parameter int unsigned ICON_DIM = IconDimDef
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         in_valid_i,
  input  wire pixel_in_t    in_data_i,
  input  wire logic         q_full_i,
  output      logic         push_o,
  output      queue_entry_t entry_o
);

  localparam int unsigned TilesPerRow = (ICON_DIM + 7) / 8;
  localparam int unsigned TileW = (TilesPerRow > 1) ? $clog2(TilesPerRow) : 1;
  localparam logic [TileW-1:0] TileLast = TileW'(TilesPerRow - 1);
  localparam logic [TileSubW-1:0] SubLast = '1;

  logic [TileSubW-1:0] sub_q, sub_d;
  logic [TileW-1:0]    col_q, col_d;
  logic [TileW-1:0]    row_q, row_d;
  logic [TileW+1:0]    col_ext, row_ext;
  logic                byte_push;

  assign push_o    = in_valid_i && !q_full_i;
  assign byte_push = push_o && (in_data_i.func == FuncPixels);

  assign col_ext = {2'b00, col_q};
  assign row_ext = {2'b00, row_q};

  always_comb begin
    entry_o.req      = in_data_i;
    entry_o.pos.x_hi = col_ext[1:0];
    entry_o.pos.y_hi = row_ext[1:0];
    entry_o.pos.sub  = sub_q;
    entry_o.pos.done = (sub_q == SubLast) && (col_q == TileLast) && (row_q == TileLast);
  end

  always_comb begin
    sub_d = sub_q;
    col_d = col_q;
    row_d = row_q;
    if (byte_push) begin
      sub_d = sub_q + 1'b1;
      if (sub_q == SubLast) begin
        if (col_q == TileLast) begin
          col_d = '0;
          row_d = (row_q == TileLast) ? '0 : row_q + 1'b1;
        end else begin
          col_d = col_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sub_q <= '0;
      col_q <= '0;
      row_q <= '0;
    end else begin
      sub_q <= sub_d;
      col_q <= col_d;
      row_q <= row_d;
    end
  end

endmodule

`default_nettype wire

### src/t4p2rgb_queue.sv
// two-entry request queue between front and back end
// depends on t4p2rgb_pkg
`default_nettype none

module t4p2rgb_queue
  import t4p2rgb_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         push_i,
  input  wire queue_entry_t push_data_i,
  output      logic         full_o,
  input  wire logic         pop_i,
  output      logic         valid_o,
  output      queue_entry_t pop_data_o
);

  localparam int unsigned PtrW = $clog2(QueueDepth);
  localparam logic [PtrW:0] CountFull = (PtrW + 1)'(QueueDepth);

  queue_entry_t    mem_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [PtrW:0]   count_q;

  assign full_o     = (count_q == CountFull);
  assign valid_o    = (count_q != '0);
  assign pop_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

`default_nettype wire

### src/t4p2rgb_back.sv
// back end: palette writes and lookups, one pixel per cycle unless the output stalls, output register
// depends on t4p2rgb_pkg and t4p2rgb_ram
`default_nettype none

module t4p2rgb_back
  import t4p2rgb_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         q_valid_i,
  input  wire queue_entry_t q_data_i,
  output      logic         pop_o,
  output      logic         out_valid_o,
  input  wire logic         out_ready_i,
  output      pixel_out_t   out_data_o
);

  logic               phase_q;
  logic               s1_valid_q;
  pixel_meta_t        s1_meta_q;
  logic               out_valid_q;
  pixel_out_t         out_data_q;
  logic               out_free, s1_free, wr_en, rd_en;
  logic [PalIdxW-1:0] rd_idx;
  logic [ColourW-1:0] colour;
  pixel_meta_t        meta;

  assign out_free = !out_valid_q || out_ready_i;
  assign s1_free  = !s1_valid_q || out_free;
  assign wr_en    = q_valid_i && (q_data_i.req.func == FuncPalette);
  assign rd_en    = q_valid_i && (q_data_i.req.func == FuncPixels) && s1_free;
  assign pop_o    = wr_en || (rd_en && phase_q);
  assign rd_idx   = phase_q ? q_data_i.req.pixel_byte[7:4] : q_data_i.req.pixel_byte[3:0];

  always_comb begin
    meta.pixel_x   = {q_data_i.pos.x_hi, q_data_i.pos.sub[1:0], phase_q};
    meta.pixel_y   = {q_data_i.pos.y_hi, q_data_i.pos.sub[4:2]};
    meta.last      = phase_q;
    meta.icon_done = phase_q && q_data_i.pos.done;
  end

  t4p2rgb_ram #(
    .WIDTH (ColourW),
    .DEPTH (PalDepth)
  ) u_palette (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (q_data_i.req.palette_index),
    .wdata_i (q_data_i.req.palette_color),
    .re_i    (rd_en),
    .raddr_i (rd_idx),
    .rdata_o (colour)
  );

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      s1_meta_q <= meta;
    end
    if (out_free) begin
      out_data_q.pixel_x   <= s1_meta_q.pixel_x;
      out_data_q.pixel_y   <= s1_meta_q.pixel_y;
      out_data_q.red       <= expand_chan(colour[4:0]);
      out_data_q.green     <= expand_chan(colour[9:5]);
      out_data_q.blue      <= expand_chan(colour[14:10]);
      out_data_q.last      <= s1_meta_q.last;
      out_data_q.icon_done <= s1_meta_q.icon_done;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= 1'b0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (rd_en) begin
        phase_q <= !phase_q;
      end
      if (rd_en) begin
        s1_valid_q <= 1'b1;
      end else if (out_free) begin
        s1_valid_q <= 1'b0;
      end
      if (out_free) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire

### src/tiled_4bpp_palette_to_rgb888.sv
// path: the first pixel of a byte passes the queue, the palette ram read register and the
// output register, the second follows on a second palette lookup; a palette write is popped
// and written in the same cycle; throughput: one pixel per cycle while the output is not
// stalled, set by the single read port of the palette ram
// reset: tile position and queue cleared, palette contents undefined until written
`default_nettype none

module tiled_4bpp_palette_to_rgb888
  import t4p2rgb_pkg::*;
#(
  parameter int unsigned ICON_DIM = IconDimDef
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output      logic       in_ready_o,
  input  wire pixel_in_t  in_data_i,
  output      logic       out_valid_o,
  input  wire logic       out_ready_i,
  output      pixel_out_t out_data_o
);

  logic         push, q_full, q_valid, pop;
  queue_entry_t push_entry, pop_entry;

  assign in_ready_o = !q_full;

  t4p2rgb_front #(
    .ICON_DIM (ICON_DIM)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_data_i  (in_data_i),
    .q_full_i   (q_full),
    .push_o     (push),
    .entry_o    (push_entry)
  );

  t4p2rgb_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_entry),
    .full_o      (q_full),
    .pop_i       (pop),
    .valid_o     (q_valid),
    .pop_data_o  (pop_entry)
  );

  t4p2rgb_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_data_i    (pop_entry),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire
